### hw/rtl/fxnc_pkg.sv
`default_nettype none
package fxnc_pkg;
  localparam int PATH_TAPS_DEF    = 400;
  localparam int CONTROL_TAPS_DEF = 200;
  localparam int SAMPLE_W  = 16;
  localparam int REF_W     = 12;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 16;
  localparam logic [15:0] STEP_RESET = 16'd1678;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STEP = CFG_IDX_W'(1);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic hi_same;
    hi_same = (v[63:31] == {33{1'b0}}) || (v[63:31] == {33{1'b1}});
    if (hi_same) return v[31:0];
    else if (v[63]) return 32'sh8000_0000;
    else return 32'sh7fff_ffff;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    if (v > 32'sd32767) return 16'sh7fff;
    else if (v < -32'sd32768) return 16'sh8000;
    else return v[15:0];
  endfunction
endpackage
`default_nettype wire

### hw/rtl/fxnc_in_if.sv
`default_nettype none
interface fxnc_in_if import fxnc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mic_sample;
  logic        [REF_W-1:0]    ref_sample;
  logic signed [SAMPLE_W-1:0] excitation;
  logic                       pause;
  modport source (output valid, mic_sample, ref_sample, excitation, pause, input ready);
  modport sink   (input valid, mic_sample, ref_sample, excitation, pause, output ready);
endinterface
`default_nettype wire

### hw/rtl/fxnc_out_if.sv
`default_nettype none
interface fxnc_out_if import fxnc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] speaker_sample;
  modport source (output valid, speaker_sample, input ready);
  modport sink   (input valid, speaker_sample, output ready);
endinterface
`default_nettype wire

### hw/rtl/fxnc_cfg_if.sv
`default_nettype none
interface fxnc_cfg_if import fxnc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hw/rtl/fxlms_noise_canceller.sv
`default_nettype none
// One input transaction at a time; ready is high only while idle, from the cycle in which a result is presented.
// Identify: one shared MAC, one tap per cycle through the filter pass and again
// through the update pass.
// Cancel: path filter pass, control filter pass, then update pass; paused cancel: no passes.
// After reset a clearing pass zeroes all stores; input is held off meanwhile,
// configuration writes are taken.
module fxlms_noise_canceller import fxnc_pkg::*; #(
  parameter int PATH_TAPS    = PATH_TAPS_DEF,
  parameter int CONTROL_TAPS = CONTROL_TAPS_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  fxnc_in_if.sink    in_ch,
  fxnc_out_if.source out_ch,
  fxnc_cfg_if.sink   cfg_ch
);
  localparam int PAW  = $clog2(PATH_TAPS);
  localparam int CAW  = $clog2(CONTROL_TAPS);
  localparam int MAXN = (PATH_TAPS > CONTROL_TAPS) ? PATH_TAPS : CONTROL_TAPS;
  localparam int CNTW = $clog2(MAXN + 1);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_WRH  = 4'd2;
  localparam logic [3:0] S_MAC  = 4'd3;
  localparam logic [3:0] S_ERR  = 4'd4;
  localparam logic [3:0] S_GAIN = 4'd5;
  localparam logic [3:0] S_GDIV = 4'd6;
  localparam logic [3:0] S_UPD  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]         state_r;
  logic               mode_r;
  logic [15:0]        step_r;
  logic signed [15:0] mic_r, x_r, exc_r;
  logic               paused_r, sel_r;
  logic [PAW-1:0]     ipos_r, ppos_r;
  logic [CAW-1:0]     cpos_r;
  logic [CNTW-1:0]    cnt_r, hidx_r, j1_r, j2_r, lim;
  logic               v1_r, v2_r, issue;
  logic signed [63:0] acc_r, prod_r;
  logic signed [31:0] e_r, g_r, y_r, tapd_r;
  logic               out_valid_r;
  logic signed [15:0] out_data_r;

  logic [31:0] ptap_rd, ctap_rd, flt_rd;
  logic [15:0] exh_rd, rhp_rd, rhc_rd;
  logic        clr_we, upd_we, wrh;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [31:0] acc_sat, upd_sum, hist_ext, tap_cur;
  logic signed [63:0] upd_sh, mic_q28, diff;

  assign lim    = sel_r ? CNTW'(CONTROL_TAPS) : CNTW'(PATH_TAPS);
  assign issue  = ((state_r == S_MAC) || (state_r == S_UPD)) && (cnt_r < lim);
  assign clr_we = (state_r == S_CLR);
  assign upd_we = (state_r == S_UPD) && v2_r;
  assign wrh    = (state_r == S_WRH);

  assign in_ch.ready           = (state_r == S_IDLE);
  assign cfg_ch.ready          = 1'b1;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.speaker_sample = out_data_r;

  fxnc_ram #(.WIDTH(32), .DEPTH(PATH_TAPS)) u_ptap (
    .clk, .we(clr_we ? (cnt_r < CNTW'(PATH_TAPS)) : (upd_we && !sel_r)),
    .waddr(clr_we ? cnt_r[PAW-1:0] : j2_r[PAW-1:0]),
    .wdata(clr_we ? 32'd0 : upd_sum), .raddr(cnt_r[PAW-1:0]), .rdata(ptap_rd));
  fxnc_ram #(.WIDTH(32), .DEPTH(CONTROL_TAPS)) u_ctap (
    .clk, .we(clr_we ? (cnt_r < CNTW'(CONTROL_TAPS)) : (upd_we && sel_r)),
    .waddr(clr_we ? cnt_r[CAW-1:0] : j2_r[CAW-1:0]),
    .wdata(clr_we ? 32'd0 : upd_sum), .raddr(cnt_r[CAW-1:0]), .rdata(ctap_rd));
  fxnc_ram #(.WIDTH(16), .DEPTH(PATH_TAPS)) u_exh (
    .clk, .we(clr_we ? (cnt_r < CNTW'(PATH_TAPS)) : (wrh && !mode_r)),
    .waddr(clr_we ? cnt_r[PAW-1:0] : ipos_r),
    .wdata(clr_we ? 16'd0 : exc_r), .raddr(hidx_r[PAW-1:0]), .rdata(exh_rd));
  fxnc_ram #(.WIDTH(16), .DEPTH(PATH_TAPS)) u_rhp (
    .clk, .we(clr_we ? (cnt_r < CNTW'(PATH_TAPS)) : (wrh && mode_r)),
    .waddr(clr_we ? cnt_r[PAW-1:0] : ppos_r),
    .wdata(clr_we ? 16'd0 : x_r), .raddr(hidx_r[PAW-1:0]), .rdata(rhp_rd));
  fxnc_ram #(.WIDTH(16), .DEPTH(CONTROL_TAPS)) u_rhc (
    .clk, .we(clr_we ? (cnt_r < CNTW'(CONTROL_TAPS)) : (wrh && mode_r)),
    .waddr(clr_we ? cnt_r[CAW-1:0] : cpos_r),
    .wdata(clr_we ? 16'd0 : x_r), .raddr(hidx_r[CAW-1:0]), .rdata(rhc_rd));
  fxnc_ram #(.WIDTH(32), .DEPTH(CONTROL_TAPS)) u_flt (
    .clk, .we(clr_we ? (cnt_r < CNTW'(CONTROL_TAPS)) : ((state_r == S_ERR) && mode_r && !sel_r)),
    .waddr(clr_we ? cnt_r[CAW-1:0] : cpos_r),
    .wdata(clr_we ? 32'd0 : acc_sat), .raddr(hidx_r[CAW-1:0]), .rdata(flt_rd));

  always_comb begin
    tap_cur = sel_r ? ctap_rd : ptap_rd;
    if (!mode_r) hist_ext = 32'(signed'(exh_rd));
    else if (state_r == S_UPD) hist_ext = flt_rd;
    else if (sel_r) hist_ext = 32'(signed'(rhc_rd));
    else hist_ext = 32'(signed'(rhp_rd));
    if (state_r == S_GAIN) begin
      mul_a = signed'({17'd0, step_r});
      mul_b = 33'(e_r);
    end else if (state_r == S_UPD) begin
      mul_a = 33'(g_r);
      mul_b = 33'(hist_ext);
    end else begin
      mul_a = 33'(tap_cur);
      mul_b = 33'(hist_ext);
    end
    mul_p   = mul_a * mul_b;
    acc_sat = sat32(acc_r >>> 15);
    mic_q28 = 64'(mic_r) <<< 16;
    diff    = mic_q28 - 64'(acc_sat);
    upd_sh  = mode_r ? (prod_r >>> 28) : (prod_r >>> 15);
    upd_sum = sat32(64'(tapd_r) + upd_sh);
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_p[63:0];
    tapd_r <= tap_cur;
    j1_r   <= cnt_r;
    j2_r   <= j1_r;
    if (!rst_n) begin
      state_r     <= S_CLR;
      mode_r      <= 1'b0;
      step_r      <= STEP_RESET;
      ipos_r      <= '0;
      ppos_r      <= '0;
      cpos_r      <= '0;
      cnt_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        if (cfg_ch.index == REG_MODE) mode_r <= cfg_ch.data[0];
        else if (cfg_ch.index == REG_STEP) step_r <= cfg_ch.data;
      end
      if (out_valid_r && out_ch.ready && (state_r != S_OUT)) out_valid_r <= 1'b0;
      v1_r <= issue;
      v2_r <= v1_r;
      if (issue) begin
        cnt_r  <= cnt_r + 1'b1;
        hidx_r <= (hidx_r == lim - 1'b1) ? '0 : hidx_r + 1'b1;
      end
      if ((state_r == S_MAC) && v2_r) acc_r <= acc_r + prod_r;
      case (state_r)
        S_CLR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNTW'(MAXN - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            mic_r    <= in_ch.mic_sample;
            x_r      <= {~in_ch.ref_sample[11], in_ch.ref_sample[10:0], 4'd0};
            exc_r    <= in_ch.excitation;
            paused_r <= mode_r && in_ch.pause;
            state_r  <= (mode_r && in_ch.pause) ? S_OUT : S_WRH;
          end
        end
        S_WRH: begin
          sel_r   <= 1'b0;
          cnt_r   <= '0;
          acc_r   <= '0;
          hidx_r  <= mode_r ? CNTW'(ppos_r) : CNTW'(ipos_r);
          state_r <= S_MAC;
        end
        S_MAC: begin
          if (!issue && !v1_r && !v2_r) state_r <= S_ERR;
        end
        S_ERR: begin
          if (!mode_r) begin
            e_r     <= sat32(diff);
            state_r <= S_GAIN;
          end else if (!sel_r) begin
            sel_r   <= 1'b1;
            cnt_r   <= '0;
            acc_r   <= '0;
            hidx_r  <= CNTW'(cpos_r);
            state_r <= S_MAC;
          end else begin
            y_r     <= acc_sat;
            e_r     <= mic_q28[31:0];
            state_r <= S_GAIN;
          end
        end
        S_GAIN: state_r <= S_GDIV;
        S_GDIV: begin
          g_r     <= prod_r[55:24];
          cnt_r   <= '0;
          hidx_r  <= mode_r ? CNTW'(cpos_r) : CNTW'(ipos_r);
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (!issue && !v1_r && !v2_r) state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            if (paused_r) begin
              out_data_r <= '0;
            end else if (!mode_r) begin
              out_data_r <= exc_r;
              ipos_r <= (ipos_r == '0) ? PAW'(PATH_TAPS - 1) : ipos_r - 1'b1;
            end else begin
              out_data_r <= sat16(-(y_r >>> 13));
              ppos_r <= (ppos_r == '0) ? PAW'(PATH_TAPS - 1) : ppos_r - 1'b1;
              cpos_r <= (cpos_r == '0) ? CAW'(CONTROL_TAPS - 1) : cpos_r - 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### hw/rtl/fxnc_ram.sv
`default_nettype none
module fxnc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 400
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
